// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the allocator rtl, clocked on clk, reset on rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property check, off while in reset
`define PBA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define PBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define PBA_ASSERT(label, prop)
`define PBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// constants, codes and types of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;

    localparam int ADDR_W     = 32;
    localparam int OPCODE_W   = 3;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
    localparam int WORD_IDX_W = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int TAKE_W     = BIT_W + 1;

    localparam logic [ADDR_W-1:0] EXHAUSTED_ADDR = 32'hDEAD_C0DE;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC         = 3'd0,
        OP_FREE_PAGE     = 3'd1,
        OP_RESERVE_PAGE  = 3'd2,
        OP_FREE_RANGE    = 3'd3,
        OP_RESERVE_RANGE = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANGE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } ram_cmd_t;

    // index of the lowest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] lowest_set_bit(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: src/pba_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_channels
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
interface pba_req_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::OPCODE_W-1:0]  opcode;
    logic [pba_pkg::ADDR_W-1:0]    byte_address;
    logic [pba_pkg::COUNT_W-1:0]   page_count;

    modport source (output valid, output opcode, output byte_address, output page_count,
                    input ready);
    modport sink   (input valid, input opcode, input byte_address, input page_count,
                    output ready);
endinterface

interface pba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::ADDR_W-1:0]    page_address;
    logic [pba_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output page_address, output status, input ready);
    modport sink   (input valid, input page_address, input status, output ready);
endinterface

// File: src/pba_bitmap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_bitmap_ram
// free bitmap store, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module pba_bitmap_ram (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pba_pkg::ram_cmd_t               cmd,
    output logic [pba_pkg::WORD_BITS-1:0]   rd_data
);

    logic [pba_pkg::WORD_BITS-1:0] bitmap_mem [pba_pkg::WORDS];
    logic [pba_pkg::WORD_BITS-1:0] rd_word_reg;
    logic [pba_pkg::WORDS-1:0]     valid_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            bitmap_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_word_reg <= bitmap_mem[cmd.rd_addr];
        end
    end

    // never-written words read as zero (reserved)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// File: src/page_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// first-fit page frame allocator over a free-page bitmap
// ----------------------------------------------------------------------------
// One request at a time. A 32-word bitmap memory (registered read data)
// holds one bit per page, 1 = free; after reset every page is reserved.
// Alloc reads one word per cycle from word 0 upward, up to all 32 words,
// and clears the lowest set bit of the first nonzero word. Free/reserve of
// one page and of a range walk the pages a word at a time, with a read step
// (ST_RANGE) and a write step (ST_WRITE) per touched word; a stretch of
// pages that lies beyond the map is skipped without a memory access. The
// result sits in an output register, so the core goes back to idle while a
// finished response waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_bitmap_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    pba_req_if.sink     req,
    pba_rsp_if.source   rsp
);

    // state and working registers
    pba_pkg::state_t                        state_reg, state_next;
    logic [pba_pkg::PAGE_NUM_W-1:0]         cur_reg, cur_next;
    logic [pba_pkg::COUNT_W-1:0]            rem_reg, rem_next;
    logic                                   free_reg, free_next;
    logic [pba_pkg::WORD_IDX_W-1:0]         idx_reg, idx_next;
    logic [pba_pkg::WORD_BITS-1:0]          mask_reg, mask_next;
    logic [pba_pkg::TAKE_W-1:0]             take_reg, take_next;
    logic [pba_pkg::ADDR_W-1:0]             res_addr_reg, res_addr_next;
    logic [pba_pkg::STATUS_W-1:0]           res_status_reg, res_status_next;

    // response register
    logic                                   rsp_valid_reg, rsp_valid_next;
    logic [pba_pkg::ADDR_W-1:0]             rsp_addr_reg, rsp_addr_next;
    logic [pba_pkg::STATUS_W-1:0]           rsp_status_reg, rsp_status_next;

    pba_pkg::ram_cmd_t                      cmd;
    logic [pba_pkg::WORD_BITS-1:0]          word_rd;
    logic [pba_pkg::BIT_W-1:0]              bit_lo;
    logic                                   req_ready;

    // range walk helpers
    logic                                   in_map;
    logic [pba_pkg::PAGE_NUM_W:0]           span;
    logic [pba_pkg::COUNT_W-1:0]            skip_n;
    logic [pba_pkg::TAKE_W-1:0]             avail;
    logic [pba_pkg::TAKE_W-1:0]             take;
    logic [pba_pkg::WORD_BITS-1:0]          mask;

    pba_bitmap_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (word_rd)
    );

    assign bit_lo = pba_pkg::lowest_set_bit(word_rd);

    // page number beyond the map: skip up to the 2^20 wrap in one step
    assign in_map = cur_reg < pba_pkg::PAGE_NUM_W'(pba_pkg::PAGE_COUNT);
    assign span   = {1'b1, {pba_pkg::PAGE_NUM_W{1'b0}}} - {1'b0, cur_reg};
    assign skip_n = (span > (pba_pkg::PAGE_NUM_W + 1)'(rem_reg)) ? rem_reg
                  : pba_pkg::COUNT_W'(span);

    // pages left in the current word, capped by what remains of the range
    assign avail = pba_pkg::TAKE_W'(pba_pkg::WORD_BITS)
                 - pba_pkg::TAKE_W'(cur_reg[pba_pkg::BIT_W-1:0]);
    assign take  = (pba_pkg::COUNT_W'(avail) > rem_reg) ? pba_pkg::TAKE_W'(rem_reg) : avail;
    assign mask  = (~({pba_pkg::WORD_BITS{1'b1}} << take)) << cur_reg[pba_pkg::BIT_W-1:0];

    assign req.ready        = req_ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.page_address = rsp_addr_reg;
    assign rsp.status       = rsp_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pba_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        free_reg       <= free_next;
        idx_reg        <= idx_next;
        mask_reg       <= mask_next;
        take_reg       <= take_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        free_next       = free_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        take_next       = take_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        cmd             = '0;
        req_ready       = 1'b0;

        unique case (state_reg)
            pba_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = pba_pkg::STATUS_OK;
                    cur_next        = req.byte_address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
                    free_next       = (req.opcode == pba_pkg::OP_FREE_PAGE)
                                   || (req.opcode == pba_pkg::OP_FREE_RANGE);
                    unique case (req.opcode) inside
                        pba_pkg::OP_ALLOC:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            idx_next    = '0;
                            state_next  = pba_pkg::ST_SCAN;
                        end
                        pba_pkg::OP_FREE_PAGE, pba_pkg::OP_RESERVE_PAGE:
                        begin
                            rem_next   = pba_pkg::COUNT_W'(1);
                            state_next = pba_pkg::ST_RANGE;
                        end
                        pba_pkg::OP_FREE_RANGE, pba_pkg::OP_RESERVE_RANGE:
                        begin
                            rem_next   = req.page_count;
                            state_next = pba_pkg::ST_RANGE;
                        end
                        default:
                        begin
                            // undefined opcodes answer zero / ok
                            state_next = pba_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            pba_pkg::ST_SCAN:
            begin
                if (word_rd != '0)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_addr   = idx_reg;
                    cmd.wr_data   = word_rd & ~(pba_pkg::WORD_BITS'(1) << bit_lo);
                    res_addr_next = pba_pkg::ADDR_W'({idx_reg, bit_lo}) << pba_pkg::PAGE_SHIFT;
                    state_next    = pba_pkg::ST_FINISH;
                end
                else if (idx_reg == pba_pkg::WORD_IDX_W'(pba_pkg::WORDS - 1))
                begin
                    res_addr_next   = pba_pkg::EXHAUSTED_ADDR;
                    res_status_next = pba_pkg::STATUS_EMPTY;
                    state_next      = pba_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
            end

            pba_pkg::ST_RANGE:
            begin
                if (rem_reg == '0)
                begin
                    state_next = pba_pkg::ST_FINISH;
                end
                else if (!in_map)
                begin
                    res_status_next = pba_pkg::STATUS_RANGE;
                    cur_next        = cur_reg + pba_pkg::PAGE_NUM_W'(skip_n);
                    rem_next        = rem_reg - skip_n;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = cur_reg[pba_pkg::BIT_W +: pba_pkg::WORD_IDX_W];
                    mask_next   = mask;
                    take_next   = take;
                    state_next  = pba_pkg::ST_WRITE;
                end
            end

            pba_pkg::ST_WRITE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = cur_reg[pba_pkg::BIT_W +: pba_pkg::WORD_IDX_W];
                cmd.wr_data = free_reg ? (word_rd | mask_reg) : (word_rd & ~mask_reg);
                cur_next    = cur_reg + pba_pkg::PAGE_NUM_W'(take_reg);
                rem_next    = rem_reg - pba_pkg::COUNT_W'(take_reg);
                state_next  = pba_pkg::ST_RANGE;
            end

            pba_pkg::ST_FINISH:
            begin
                // hand off once the response register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = pba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase
    end

    // the bitmap memory never sees a read and a write in one cycle
    `PBA_ASSERT(a_no_rd_wr_overlap, !(cmd.rd_en && cmd.wr_en))
    // an accepted alloc request starts the word scan
    `PBA_ASSERT_NEXT(a_alloc_scans, req.valid && req.ready && req.opcode == pba_pkg::OP_ALLOC,
                     state_reg == pba_pkg::ST_SCAN)
    // every word update shrinks the remaining page count
    `PBA_ASSERT_NEXT(a_range_progress, state_reg == pba_pkg::ST_WRITE,
                     rem_reg < $past(rem_reg))
    // a new response is only raised out of the finish step
    `PBA_ASSERT(a_rsp_from_finish, !rsp_valid_next || rsp_valid_reg
                                   || state_reg == pba_pkg::ST_FINISH)

endmodule

// File: tb/sv/page_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core_tb
// self-checking regression for the first-fit page bitmap allocator
// ----------------------------------------------------------------------------
// A driver process feeds requests from a backlog queue onto the request
// channel. Each accepted request is applied to a shadow copy of the free-page
// bitmap, and the response that the shadow gives is queued. A monitor process
// takes responses from the response channel and compares them, field by field,
// with the oldest queued response. Both sides idle at random, with calm
// stretches in between. A directed opening covers the corner cases, then a
// long random mix follows, with bursts that force deep scans and exhaustion.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core_tb;

    // opcodes that the core must answer without touching the bitmap
    localparam logic [pba_pkg::OPCODE_W-1:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [pba_pkg::OPCODE_W-1:0] OP_UNKNOWN_HI = 3'd7;

    localparam int          RANDOM_ITEMS = 1850;
    localparam int          DRAIN_CYCLES = 80;
    // covers the slowest request plus the longest gap and stall
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [pba_pkg::OPCODE_W-1:0] opcode;
        logic [pba_pkg::ADDR_W-1:0]   byte_address;
        logic [pba_pkg::COUNT_W-1:0]  page_count;
    } page_req_t;

    typedef struct packed {
        logic [pba_pkg::ADDR_W-1:0]   page_address;
        logic [pba_pkg::STATUS_W-1:0] status;
    } page_rsp_t;

    logic clk;
    logic rst_n;

    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();

    page_bitmap_allocator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow of the free-page bitmap, 1 = free, all reserved after reset
    logic [pba_pkg::WORD_BITS-1:0] free_page_map [pba_pkg::WORDS];

    page_req_t   request_backlog [$];
    page_rsp_t   awaited_responses [$];
    page_req_t   next_req;
    page_req_t   taken_req;
    page_rsp_t   oldest_rsp;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        calm = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // shadow bitmap
    // ------------------------------------------------------------------------

    // set or clear the bit of the page holding addr; 0 if the page is off the map
    function automatic logic mark_page(input logic [pba_pkg::ADDR_W-1:0] addr,
                                       input logic make_free);
        int unsigned page_num;
        page_num = addr >> pba_pkg::PAGE_SHIFT;
        if (page_num >= pba_pkg::PAGE_COUNT)
            return 1'b0;
        free_page_map[page_num / pba_pkg::WORD_BITS][page_num % pba_pkg::WORD_BITS] = make_free;
        return 1'b1;
    endfunction

    // apply one request to the shadow bitmap and return the response it owes
    function automatic page_rsp_t apply_page_request(input page_req_t r);
        page_rsp_t                  answer;
        logic                       found;
        int unsigned                bit_idx;
        logic [pba_pkg::ADDR_W-1:0] page_addr;
        answer.page_address = '0;
        answer.status       = pba_pkg::STATUS_OK;
        found               = 1'b0;
        case (r.opcode) inside
            pba_pkg::OP_ALLOC:
            begin
                // first nonzero word, then its lowest set bit
                for (int w = 0; w < pba_pkg::WORDS && !found; w++)
                begin
                    if (free_page_map[w] != '0)
                    begin
                        bit_idx = 0;
                        while (!free_page_map[w][bit_idx])
                            bit_idx++;
                        free_page_map[w][bit_idx] = 1'b0;
                        answer.page_address = pba_pkg::ADDR_W'(
                            (w * pba_pkg::WORD_BITS + bit_idx) * pba_pkg::PAGE_BYTES);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    answer.page_address = pba_pkg::EXHAUSTED_ADDR;
                    answer.status       = pba_pkg::STATUS_EMPTY;
                end
            end
            pba_pkg::OP_FREE_PAGE, pba_pkg::OP_RESERVE_PAGE:
            begin
                if (!mark_page(r.byte_address, r.opcode == pba_pkg::OP_FREE_PAGE))
                    answer.status = pba_pkg::STATUS_RANGE;
            end
            pba_pkg::OP_FREE_RANGE, pba_pkg::OP_RESERVE_RANGE:
            begin
                // page addresses wrap at 2^32; pages off the map are skipped
                for (int i = 0; i < int'(r.page_count); i++)
                begin
                    page_addr = r.byte_address
                              + pba_pkg::ADDR_W'(i * pba_pkg::PAGE_BYTES);
                    if (!mark_page(page_addr, r.opcode == pba_pkg::OP_FREE_RANGE))
                        answer.status = pba_pkg::STATUS_RANGE;
                end
            end
            default:
            begin
                // unknown opcode: no change, zero answer
            end
        endcase
        return answer;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_request(input logic [pba_pkg::OPCODE_W-1:0] op,
                                          input logic [pba_pkg::ADDR_W-1:0]   addr,
                                          input logic [pba_pkg::COUNT_W-1:0]  count);
        page_req_t r;
        r.opcode       = op;
        r.byte_address = addr;
        r.page_count   = count;
        request_backlog.push_back(r);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic [pba_pkg::ADDR_W-1:0] pick_address();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            // inside the map, any offset within the page
            return pba_pkg::ADDR_W'(
                ($urandom_range(0, pba_pkg::PAGE_COUNT - 1) << pba_pkg::PAGE_SHIFT)
                | $urandom_range(0, pba_pkg::PAGE_BYTES - 1));
        else if (roll < 87)
            // straddling the top of the map
            return pba_pkg::ADDR_W'(
                ($urandom_range(pba_pkg::PAGE_COUNT - 24, pba_pkg::PAGE_COUNT + 76)
                 << pba_pkg::PAGE_SHIFT)
                | $urandom_range(0, pba_pkg::PAGE_BYTES - 1));
        else if (roll < 93)
            // just below 2^32 so that ranges wrap to page 0
            return 32'hFFFF_FFFF
                 - pba_pkg::ADDR_W'($urandom_range(0, 64 * pba_pkg::PAGE_BYTES));
        else
            return pba_pkg::ADDR_W'($urandom);
    endfunction

    function automatic logic [pba_pkg::COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return pba_pkg::COUNT_W'($urandom_range(0, 40));
        else if (roll < 92)
            return pba_pkg::COUNT_W'($urandom_range(41, 300));
        else if (roll < 97)
            return pba_pkg::COUNT_W'($urandom_range(301, pba_pkg::PAGE_COUNT - 1));
        else
            return pba_pkg::COUNT_W'(pba_pkg::PAGE_COUNT);
    endfunction

    function automatic page_req_t random_request();
        page_req_t   r;
        int unsigned roll;
        roll           = $urandom_range(0, 99);
        r.byte_address = pick_address();
        r.page_count   = pick_count();
        if (roll < 38)
        begin
            r.opcode       = pba_pkg::OP_ALLOC;
            // fields the core should ignore still toggle
            r.byte_address = pba_pkg::ADDR_W'($urandom);
            r.page_count   = pba_pkg::COUNT_W'($urandom_range(0, pba_pkg::PAGE_COUNT));
        end
        else if (roll < 58)
            r.opcode = pba_pkg::OP_FREE_PAGE;
        else if (roll < 72)
            r.opcode = pba_pkg::OP_RESERVE_PAGE;
        else if (roll < 84)
            r.opcode = pba_pkg::OP_FREE_RANGE;
        else if (roll < 97)
            r.opcode = pba_pkg::OP_RESERVE_RANGE;
        else
            r.opcode = pba_pkg::OPCODE_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence: build the backlog, reset, wait for the drain
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;

        // shadow starts with every page reserved
        foreach (free_page_map[w])
            free_page_map[w] = '0;

        // directed: exhaustion straight out of reset
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        // offset within the page is ignored
        queue_request(pba_pkg::OP_FREE_PAGE, 32'h0000_0FFF, 11'd0);
        queue_request(pba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 11'h7FF);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        // last page of the map, then the first page off it
        queue_request(pba_pkg::OP_FREE_PAGE, 32'h003F_F000, 11'd0);
        queue_request(pba_pkg::OP_FREE_PAGE, 32'h0040_0000, 11'd0);
        queue_request(pba_pkg::OP_RESERVE_PAGE, 32'hFFFF_FFFF, 11'd0);
        // alloc has to scan up to the last word
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        // empty range touches nothing
        queue_request(pba_pkg::OP_FREE_RANGE, 32'h0000_0000, 11'd0);
        queue_request(pba_pkg::OP_FREE_RANGE, 32'h0000_0ABC, 11'd1024);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        queue_request(pba_pkg::OP_RESERVE_PAGE, 32'h0000_1000, 11'd0);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        // range running off the end of the map
        queue_request(pba_pkg::OP_RESERVE_RANGE, 32'h003F_E000, 11'd4);
        // range wrapping through 2^32 back onto page 0
        queue_request(pba_pkg::OP_FREE_RANGE, 32'hFFFF_F000, 11'd5);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        queue_request(pba_pkg::OP_RESERVE_RANGE, 32'h0000_0000, 11'd1024);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        // range entirely off the map
        queue_request(pba_pkg::OP_FREE_RANGE, 32'hFFC0_0000, 11'd1024);
        // unaligned range across a word boundary
        queue_request(pba_pkg::OP_FREE_RANGE, 32'h0007_F000, 11'd33);
        queue_request(pba_pkg::OP_RESERVE_PAGE, 32'h0009_F123, 11'd0);
        queue_request(pba_pkg::OP_ALLOC, 32'h0000_0000, 11'd0);
        for (int op = OP_UNKNOWN_LO; op <= OP_UNKNOWN_HI; op++)
            queue_request(pba_pkg::OPCODE_W'(op), 32'hAAAA_5555, 11'h555);

        // random mix, now and then a burst that empties the map and then
        // leaves a lone free page or two so alloc scans deep
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                queue_request(pba_pkg::OP_RESERVE_RANGE, 32'h0000_0000,
                              pba_pkg::COUNT_W'(pba_pkg::PAGE_COUNT));
                queue_request(pba_pkg::OP_FREE_PAGE,
                              pba_pkg::ADDR_W'($urandom_range(pba_pkg::PAGE_COUNT / 2,
                              pba_pkg::PAGE_COUNT - 1) << pba_pkg::PAGE_SHIFT),
                              pba_pkg::COUNT_W'($urandom));
                queue_request(pba_pkg::OP_FREE_PAGE, pick_address(),
                              pba_pkg::COUNT_W'($urandom));
                queue_request(pba_pkg::OP_ALLOC, pba_pkg::ADDR_W'($urandom),
                              pba_pkg::COUNT_W'($urandom));
                queue_request(pba_pkg::OP_ALLOC, pba_pkg::ADDR_W'($urandom),
                              pba_pkg::COUNT_W'($urandom));
                queue_request(pba_pkg::OP_ALLOC, pba_pkg::ADDR_W'($urandom),
                              pba_pkg::COUNT_W'($urandom));
                n += 5;
            end
            else
                request_backlog.push_back(random_request());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every request taken, every response in, then a quiet tail
        while (request_backlog.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("page_bitmap_allocator_core regression: pass");
        else
            $display("page_bitmap_allocator_core regression: fail");
        $finish;
    end

    // calm stretches with no idling on either side
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            calm <= !calm;
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.opcode       <= '0;
            req_ch.byte_address <= '0;
            req_ch.page_count   <= '0;
            send_gap            <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            // a request handed over at this edge updates the shadow now
            if (req_ch.valid)
            begin
                taken_req.opcode       = req_ch.opcode;
                taken_req.byte_address = req_ch.byte_address;
                taken_req.page_count   = req_ch.page_count;
                awaited_responses.push_back(apply_page_request(taken_req));
            end
            if (send_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (request_backlog.size() != 0)
            begin
                next_req             = request_backlog.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.opcode       <= next_req.opcode;
                req_ch.byte_address <= next_req.byte_address;
                req_ch.page_count   <= next_req.page_count;
                send_gap            <= calm ? 0 : pick_gap();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // response monitor and back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $display("%0t: response with none outstanding: page_address %h status %0d",
                             $time, rsp_ch.page_address, rsp_ch.status);
                    error_count++;
                end
                else
                begin
                    oldest_rsp = awaited_responses.pop_front();
                    if (rsp_ch.page_address !== oldest_rsp.page_address)
                    begin
                        $display("%0t: page_address mismatch: expected %h actual %h",
                                 $time, oldest_rsp.page_address, rsp_ch.page_address);
                        error_count++;
                    end
                    if (rsp_ch.status !== oldest_rsp.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, oldest_rsp.status, rsp_ch.status);
                        error_count++;
                    end
                end
            end
            // stalls start at any cycle, so they land on every phase
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= pick_gap();
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("page_bitmap_allocator_core regression: fail");
            $finish;
        end
    end

endmodule
